/* design/fwte_pkg.sv */
// Shared constants and codes for the futex wait table engine.
package fwte_pkg;

    localparam int KEY_W = 62;

    localparam logic [63:0] HASH_MULT   = 64'd2654435761;
    localparam logic [63:0] KERNEL_BASE = 64'hFFFF_8000_0000_0000;

    localparam logic [1:0] CMD_WAIT   = 2'd0;
    localparam logic [1:0] CMD_WAKE   = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_UNSUP  = 2'd3;

    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_FAULT  = 3'd1;
    localparam logic [2:0] STS_AGAIN  = 3'd2;
    localparam logic [2:0] STS_FULL   = 3'd3;
    localparam logic [2:0] STS_UNSUP  = 3'd4;

    localparam logic [6:0] WAKE_MAX = 7'd64;

endpackage

/* design/fwte_key_unit.sv */
// Shared key unit: bucket hash of a selected key and compare of a stored key.
module fwte_key_unit
    import fwte_pkg::*;
#(
    parameter int HASH_BITS = 4
)
(
    input  logic [KEY_W-1:0]     hash_key,
    input  logic [KEY_W-1:0]     ref_key,
    input  logic [KEY_W-1:0]     entry_key,
    output logic [HASH_BITS-1:0] bucket,
    output logic                 key_eq
);

    logic [2*HASH_BITS-1:0] prod;

    // Only the low bits of the 64-bit product select the bucket, and those
    // depend only on the low bits of the key and of the multiplier.
    assign prod   = (2*HASH_BITS)'(hash_key[HASH_BITS-1:0])
                  * (2*HASH_BITS)'(HASH_MULT[HASH_BITS-1:0]);
    assign bucket = prod[HASH_BITS-1:0];
    assign key_eq = (entry_key == ref_key);

endmodule

/* design/fwte_table.sv */
// Waiter entry storage: key, task and link memories plus active and link-valid bits.
module fwte_table
    import fwte_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int TASK_ID_WIDTH = 8,
    parameter int IDX_W         = 6,
    parameter int LINK_W        = 7
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic [KEY_W-1:0]         rd_word,
    output logic [TASK_ID_WIDTH-1:0] rd_task,
    output logic [LINK_W-1:0]        rd_link,
    output logic                     rd_active,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic                     wr_link_en,
    input  logic [LINK_W-1:0]        wr_link,
    input  logic                     wr_entry_en,
    input  logic [KEY_W-1:0]         wr_word,
    input  logic [TASK_ID_WIDTH-1:0] wr_task,
    input  logic                     set_active,
    input  logic                     clr_active
);

    logic [KEY_W-1:0]         word_mem [TABLE_ENTRIES];
    logic [TASK_ID_WIDTH-1:0] task_mem [TABLE_ENTRIES];
    logic [LINK_W-1:0]        link_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] active_reg;
    logic [TABLE_ENTRIES-1:0] lvalid_reg;
    logic [IDX_W-1:0]         raddr_reg;
    logic                     rlv_reg;
    logic                     ract_reg;
    logic [LINK_W-1:0]        rlink_reg;

    always_ff @(posedge clk)
    begin
        if (wr_entry_en)
        begin
            word_mem[wr_addr] <= wr_word;
            task_mem[wr_addr] <= wr_task;
        end
        if (wr_link_en)
        begin
            link_mem[wr_addr] <= wr_link;
        end
        if (rd_en)
        begin
            rd_word   <= word_mem[rd_addr];
            rd_task   <= task_mem[rd_addr];
            rlink_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            lvalid_reg <= '0;
            raddr_reg  <= '0;
            rlv_reg    <= 1'b0;
            ract_reg   <= 1'b0;
        end
        else
        begin
            if (set_active)
            begin
                active_reg[wr_addr] <= 1'b1;
            end
            else if (clr_active)
            begin
                active_reg[wr_addr] <= 1'b0;
            end
            if (wr_link_en)
            begin
                lvalid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                raddr_reg <= rd_addr;
                rlv_reg   <= lvalid_reg[rd_addr];
                ract_reg  <= active_reg[rd_addr];
            end
        end
    end

    // A link never written still holds its reset value: the next slot, or none.
    always_comb
    begin
        if (rlv_reg)
        begin
            rd_link = rlink_reg;
        end
        else if (32'(raddr_reg) == TABLE_ENTRIES - 1)
        begin
            rd_link = LINK_W'(TABLE_ENTRIES);
        end
        else
        begin
            rd_link = LINK_W'(raddr_reg) + LINK_W'(1);
        end
    end

    assign rd_active = ract_reg;

endmodule

/* design/futex_wait_table_engine_core.sv */
// Top level of the futex wait table engine: command sequencer, list heads and result register.
//
// The engine keeps TABLE_ENTRIES waiter slots in 2^HASH_BITS hashed bucket chains
// and a free list. One command beat is taken at a time; cmd_stall stays high until
// the command has finished and its last result beat is in the output register.
// A wait that allocates passes through decode, allocate and emit; a rejected or
// unsupported command goes from decode straight to emit.
// Wake walks its bucket through the single read port of the entry memories:
// a matching waiter is unlinked when its entry is checked and is freed in a
// release state before the next read. Cancel first reads the slot, then walks the
// slot's bucket at one entry per cycle to unlink it.
// A wake on a good address gives one result beat per released task
// (at most 64), with last on the final one, or one empty beat if nothing matched;
// every other command gives exactly one beat. The result register frees the engine
// from the consumer, though a wake pauses while a result beat waits on res_stall.
// No clearing pass runs after reset: link memory reset values come from valid bits.
module futex_wait_table_engine_core
    import fwte_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int HASH_BITS     = 4,
    parameter int TASK_ID_WIDTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [1:0]         cmd,
    input  logic [63:0]        word_address,
    input  logic [31:0]        expected_value,
    input  logic [31:0]        current_value,
    input  logic               read_fault,
    input  logic [7:0]         task_id,
    input  logic signed [31:0] wake_limit,
    input  logic [5:0]         slot_index,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [2:0]         status,
    output logic [5:0]         slot_taken,
    output logic [7:0]         woken_task,
    output logic               woken_valid,
    output logic [6:0]         woken_so_far,
    output logic               slot_freed,
    output logic               last
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int LINK_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int BUCKETS = 1 << HASH_BITS;
    localparam logic [LINK_W-1:0] NONE = LINK_W'(TABLE_ENTRIES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_EMIT  = 4'd2;
    localparam logic [3:0] ST_ALLOC = 4'd3;
    localparam logic [3:0] ST_KCHK  = 4'd4;
    localparam logic [3:0] ST_KREL  = 4'd5;
    localparam logic [3:0] ST_KEND  = 4'd6;
    localparam logic [3:0] ST_CCHK  = 4'd7;
    localparam logic [3:0] ST_CWALK = 4'd8;
    localparam logic [3:0] ST_CREL  = 4'd9;

    logic [3:0]               state_reg, state_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic                     bad_reg, bad_next;
    logic                     fault_reg, fault_next;
    logic                     veq_reg, veq_next;
    logic [TASK_ID_WIDTH-1:0] tid_reg, tid_next;
    logic [6:0]               lim_reg, lim_next;
    logic [5:0]               sidx_reg, sidx_next;
    logic [HASH_BITS-1:0]     bkt_reg, bkt_next;
    logic [LINK_W-1:0]        cur_reg, cur_next;
    logic [LINK_W-1:0]        prev_reg, prev_next;
    logic [LINK_W-1:0]        nxt_reg, nxt_next;
    logic [6:0]               cnt_reg, cnt_next;
    logic [TASK_ID_WIDTH-1:0] ptask_reg, ptask_next;
    logic [LINK_W-1:0]        free_head_reg, free_head_next;
    logic [LINK_W-1:0]        bucket_head_reg [BUCKETS];
    logic [2:0]               stg_status_reg, stg_status_next;
    logic [5:0]               stg_slot_reg, stg_slot_next;
    logic                     stg_freed_reg, stg_freed_next;

    logic                     res_valid_reg, res_valid_next;
    logic [2:0]               status_reg, status_next;
    logic [5:0]               slot_reg, slot_next;
    logic [7:0]               wtask_reg, wtask_next;
    logic                     wvalid_reg, wvalid_next;
    logic [6:0]               wcnt_reg, wcnt_next;
    logic                     freed_reg, freed_next;
    logic                     last_reg, last_next;

    logic                     bh_we;
    logic [HASH_BITS-1:0]     bh_addr;
    logic [LINK_W-1:0]        bh_data;

    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic [KEY_W-1:0]         rd_word;
    logic [TASK_ID_WIDTH-1:0] rd_task;
    logic [LINK_W-1:0]        rd_link;
    logic                     rd_active;
    logic [IDX_W-1:0]         wr_addr;
    logic                     wr_link_en;
    logic [LINK_W-1:0]        wr_link;
    logic                     wr_entry_en;
    logic                     set_active;
    logic                     clr_active;

    logic [KEY_W-1:0]         hash_key;
    logic [HASH_BITS-1:0]     hash_bkt;
    logic                     key_eq;
    logic                     out_free;
    logic [LINK_W-1:0]        head;

    // The shared key unit hashes the command key, or during cancel the stored key.
    assign hash_key = (state_reg == ST_CCHK) ? rd_word : key_reg;

    fwte_key_unit #(
        .HASH_BITS (HASH_BITS)
    ) u_key (
        .hash_key  (hash_key),
        .ref_key   (key_reg),
        .entry_key (rd_word),
        .bucket    (hash_bkt),
        .key_eq    (key_eq)
    );

    fwte_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TASK_ID_WIDTH (TASK_ID_WIDTH),
        .IDX_W         (IDX_W),
        .LINK_W        (LINK_W)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_word     (rd_word),
        .rd_task     (rd_task),
        .rd_link     (rd_link),
        .rd_active   (rd_active),
        .wr_addr     (wr_addr),
        .wr_link_en  (wr_link_en),
        .wr_link     (wr_link),
        .wr_entry_en (wr_entry_en),
        .wr_word     (key_reg),
        .wr_task     (tid_reg),
        .set_active  (set_active),
        .clr_active  (clr_active)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign head      = bucket_head_reg[hash_bkt];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        bad_next        = bad_reg;
        fault_next      = fault_reg;
        veq_next        = veq_reg;
        tid_next        = tid_reg;
        lim_next        = lim_reg;
        sidx_next       = sidx_reg;
        bkt_next        = bkt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        cnt_next        = cnt_reg;
        ptask_next      = ptask_reg;
        free_head_next  = free_head_reg;
        stg_status_next = stg_status_reg;
        stg_slot_next   = stg_slot_reg;
        stg_freed_next  = stg_freed_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        wtask_next      = wtask_reg;
        wvalid_next     = wvalid_reg;
        wcnt_next       = wcnt_reg;
        freed_next      = freed_reg;
        last_next       = last_reg;
        res_valid_next  = res_valid_reg && res_stall;
        bh_we           = 1'b0;
        bh_addr         = bkt_reg;
        bh_data         = rd_link;
        rd_en           = 1'b0;
        rd_addr         = rd_link[IDX_W-1:0];
        wr_addr         = cur_reg[IDX_W-1:0];
        wr_link_en      = 1'b0;
        wr_link         = free_head_reg;
        wr_entry_en     = 1'b0;
        set_active      = 1'b0;
        clr_active      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    key_next   = word_address[63:2];
                    bad_next   = (word_address == 64'd0) || (word_address >= KERNEL_BASE)
                              || (word_address[1:0] != 2'b00);
                    fault_next = read_fault;
                    veq_next   = (current_value == expected_value);
                    tid_next   = TASK_ID_WIDTH'(task_id);
                    sidx_next  = slot_index;
                    if (wake_limit <= 0)
                    begin
                        lim_next = 7'd0;
                    end
                    else if (wake_limit > 32'sd64)
                    begin
                        lim_next = WAKE_MAX;
                    end
                    else
                    begin
                        lim_next = wake_limit[6:0];
                    end
                    cnt_next   = 7'd0;
                    prev_next  = NONE;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                bkt_next        = hash_bkt;
                stg_status_next = STS_OK;
                stg_slot_next   = 6'd0;
                stg_freed_next  = 1'b0;
                state_next      = ST_EMIT;
                if (cmd_reg == CMD_CANCEL)
                begin
                    if (32'(sidx_reg) < TABLE_ENTRIES)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(sidx_reg);
                        state_next = ST_CCHK;
                    end
                end
                else if (bad_reg)
                begin
                    stg_status_next = STS_FAULT;
                end
                else if (cmd_reg == CMD_UNSUP)
                begin
                    stg_status_next = STS_UNSUP;
                end
                else if (cmd_reg == CMD_WAIT)
                begin
                    if (fault_reg)
                    begin
                        stg_status_next = STS_FAULT;
                    end
                    else if (!veq_reg)
                    begin
                        stg_status_next = STS_AGAIN;
                    end
                    else if (free_head_reg == NONE)
                    begin
                        stg_status_next = STS_FULL;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = free_head_reg[IDX_W-1:0];
                        state_next = ST_ALLOC;
                    end
                end
                else
                begin
                    cur_next = head;
                    if (lim_reg == 7'd0 || head == NONE)
                    begin
                        state_next = ST_KEND;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head[IDX_W-1:0];
                        state_next = ST_KCHK;
                    end
                end
            end
            ST_ALLOC:
            begin
                // Pop the free list and push the slot at the head of its bucket.
                free_head_next = rd_link;
                wr_addr        = free_head_reg[IDX_W-1:0];
                wr_entry_en    = 1'b1;
                set_active     = 1'b1;
                wr_link_en     = 1'b1;
                wr_link        = bucket_head_reg[bkt_reg];
                bh_we          = 1'b1;
                bh_data        = free_head_reg;
                stg_slot_next  = 6'(free_head_reg);
                state_next     = ST_EMIT;
            end
            ST_KCHK:
            begin
                if (rd_active && key_eq)
                begin
                    // A held beat goes out only when a later match proves it is not last.
                    if (cnt_reg == 7'd0 || out_free)
                    begin
                        if (cnt_reg != 7'd0)
                        begin
                            res_valid_next = 1'b1;
                            status_next    = STS_OK;
                            slot_next      = 6'd0;
                            wtask_next     = 8'(ptask_reg);
                            wvalid_next    = 1'b1;
                            wcnt_next      = cnt_reg;
                            freed_next     = 1'b0;
                            last_next      = 1'b0;
                        end
                        ptask_next = rd_task;
                        cnt_next   = cnt_reg + 7'd1;
                        nxt_next   = rd_link;
                        if (prev_reg == NONE)
                        begin
                            bh_we = 1'b1;
                        end
                        else
                        begin
                            wr_addr    = prev_reg[IDX_W-1:0];
                            wr_link_en = 1'b1;
                            wr_link    = rd_link;
                        end
                        state_next = ST_KREL;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    if (rd_link == NONE)
                    begin
                        state_next = ST_KEND;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_KREL:
            begin
                wr_link_en     = 1'b1;
                clr_active     = 1'b1;
                free_head_next = cur_reg;
                if (cnt_reg < lim_reg && nxt_reg != NONE)
                begin
                    cur_next   = nxt_reg;
                    rd_en      = 1'b1;
                    rd_addr    = nxt_reg[IDX_W-1:0];
                    state_next = ST_KCHK;
                end
                else
                begin
                    state_next = ST_KEND;
                end
            end
            ST_KEND:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = STS_OK;
                    slot_next      = 6'd0;
                    wtask_next     = (cnt_reg != 7'd0) ? 8'(ptask_reg) : 8'd0;
                    wvalid_next    = (cnt_reg != 7'd0);
                    wcnt_next      = cnt_reg;
                    freed_next     = 1'b0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CCHK:
            begin
                if (rd_active && rd_task == tid_reg)
                begin
                    bkt_next  = hash_bkt;
                    cur_next  = head;
                    prev_next = NONE;
                    if (head == NONE)
                    begin
                        state_next = ST_CREL;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head[IDX_W-1:0];
                        state_next = ST_CWALK;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_CWALK:
            begin
                if (cur_reg == LINK_W'(sidx_reg))
                begin
                    if (prev_reg == NONE)
                    begin
                        bh_we = 1'b1;
                    end
                    else
                    begin
                        wr_addr    = prev_reg[IDX_W-1:0];
                        wr_link_en = 1'b1;
                        wr_link    = rd_link;
                    end
                    state_next = ST_CREL;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    if (rd_link == NONE)
                    begin
                        state_next = ST_CREL;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_CREL:
            begin
                wr_addr        = IDX_W'(sidx_reg);
                wr_link_en     = 1'b1;
                clr_active     = 1'b1;
                free_head_next = LINK_W'(sidx_reg);
                stg_freed_next = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = stg_status_reg;
                    slot_next      = stg_slot_reg;
                    wtask_next     = 8'd0;
                    wvalid_next    = 1'b0;
                    wcnt_next      = 7'd0;
                    freed_next     = stg_freed_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            free_head_reg <= '0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                bucket_head_reg[i] <= NONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            free_head_reg <= free_head_next;
            if (bh_we)
            begin
                bucket_head_reg[bh_addr] <= bh_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        bad_reg        <= bad_next;
        fault_reg      <= fault_next;
        veq_reg        <= veq_next;
        tid_reg        <= tid_next;
        lim_reg        <= lim_next;
        sidx_reg       <= sidx_next;
        bkt_reg        <= bkt_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        cnt_reg        <= cnt_next;
        ptask_reg      <= ptask_next;
        stg_status_reg <= stg_status_next;
        stg_slot_reg   <= stg_slot_next;
        stg_freed_reg  <= stg_freed_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        wtask_reg      <= wtask_next;
        wvalid_reg     <= wvalid_next;
        wcnt_reg       <= wcnt_next;
        freed_reg      <= freed_next;
        last_reg       <= last_next;
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign slot_taken   = slot_reg;
    assign woken_task   = wtask_reg;
    assign woken_valid  = wvalid_reg;
    assign woken_so_far = wcnt_reg;
    assign slot_freed   = freed_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    // Every accepted command beat starts decoding in the next cycle.
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == ST_DEC))
        else $error("accepted command did not enter decode");

    // A released task always carries a nonzero running count.
    a_woken_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && woken_valid) |-> (woken_so_far != 7'd0))
        else $error("woken beat with zero count");

    // A freed slot is reported only on a single ok beat.
    a_freed_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && slot_freed) |-> (status == STS_OK && last && !woken_valid))
        else $error("freed slot on a malformed beat");

    // A beat that is not last only comes from a wake that released a task.
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !last) |-> woken_valid)
        else $error("non-final beat without a released task");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the futex wait table engine core.
`timescale 1ns / 100ps

module testbench;
    import fwte_pkg::*;

    localparam int ENTRIES   = 64;
    localparam int HBITS     = 4;
    localparam int NONE      = ENTRIES;
    localparam int MAX_SHOWN = 10;

    // One result beat as the engine should deliver it.
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot_taken;
        logic [7:0] woken_task;
        logic       woken_valid;
        logic [6:0] woken_so_far;
        logic       slot_freed;
        logic       last;
    } beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    logic [1:0]         cmd = CMD_WAIT;
    logic [63:0]        word_address = '0;
    logic [31:0]        expected_value = '0;
    logic [31:0]        current_value = '0;
    logic               read_fault = 1'b0;
    logic [7:0]         task_id = '0;
    logic signed [31:0] wake_limit = '0;
    logic [5:0]         slot_index = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic [2:0]         status;
    logic [5:0]         slot_taken;
    logic [7:0]         woken_task;
    logic               woken_valid;
    logic [6:0]         woken_so_far;
    logic               slot_freed;
    logic               last;

    futex_wait_table_engine_core uut (.*);

    // Shadow copy of the waiter table, kept in step with accepted commands.
    logic [61:0] slot_key [ENTRIES];
    logic [7:0]  slot_owner [ENTRIES];
    bit          slot_busy [ENTRIES];
    int          slot_next [ENTRIES];
    int          chain_head [1 << HBITS];
    int          free_top;

    beat_t       pending_results [$];
    logic [63:0] addr_pool [8];
    int          mismatches = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_off_cycles = 0;
    bit          offering = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Generous fixed limit: far above the slowest legal run.
    initial begin
        #20ms;
        $display("** futex_wait_table_engine_core: FAILED **");
        $finish;
    end

    function automatic int hash_bucket(logic [61:0] key);
        logic [63:0] prod;
        prod = {2'b00, key} * HASH_MULT;
        return int'(prod[HBITS-1:0]);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i]   = '0;
            slot_owner[i] = '0;
            slot_busy[i]  = 1'b0;
            slot_next[i]  = (i + 1 < ENTRIES) ? i + 1 : NONE;
        end
        for (int b = 0; b < (1 << HBITS); b++)
            chain_head[b] = NONE;
        free_top = 0;
    endfunction

    function automatic void push_beat(logic [2:0] st, int slot, logic [7:0] tsk,
                                      bit wv, int sofar, bit freed, bit lst);
        beat_t r;
        r.status       = st;
        r.slot_taken   = slot[5:0];
        r.woken_task   = tsk;
        r.woken_valid  = wv;
        r.woken_so_far = sofar[6:0];
        r.slot_freed   = freed;
        r.last         = lst;
        pending_results.push_back(r);
    endfunction

    // Works out the result beats of one accepted command and updates the table.
    function automatic void predict_futex_cmd(logic [1:0] op, logic [63:0] addr,
            logic [31:0] expv, logic [31:0] curv, bit fault, logic [7:0] tsk,
            logic signed [31:0] lim_in, logic [5:0] sidx);
        logic [61:0] key;
        bit          bad;
        int          b, prev, cur, nxt, steps, woken, lim, s;
        key = addr[63:2];
        bad = (addr == 0) || (addr >= KERNEL_BASE) || (addr[1:0] != 2'b00);
        if (op == CMD_CANCEL) begin
            s = int'(sidx);
            if (slot_busy[s] && slot_owner[s] == tsk) begin
                b = hash_bucket(slot_key[s]);
                prev = NONE;
                cur = chain_head[b];
                steps = 0;
                while (cur < ENTRIES && steps < ENTRIES) begin
                    steps++;
                    if (cur == s) begin
                        if (prev == NONE) chain_head[b] = slot_next[cur];
                        else slot_next[prev] = slot_next[cur];
                        break;
                    end
                    prev = cur;
                    cur = slot_next[cur];
                end
                slot_busy[s] = 1'b0;
                slot_next[s] = free_top;
                free_top = s;
                push_beat(STS_OK, 0, 0, 0, 0, 1, 1);
            end else begin
                push_beat(STS_OK, 0, 0, 0, 0, 0, 1);
            end
        end else if (bad) begin
            push_beat(STS_FAULT, 0, 0, 0, 0, 0, 1);
        end else if (op == CMD_UNSUP) begin
            push_beat(STS_UNSUP, 0, 0, 0, 0, 0, 1);
        end else if (op == CMD_WAIT) begin
            if (fault) push_beat(STS_FAULT, 0, 0, 0, 0, 0, 1);
            else if (curv != expv) push_beat(STS_AGAIN, 0, 0, 0, 0, 0, 1);
            else if (free_top >= ENTRIES) push_beat(STS_FULL, 0, 0, 0, 0, 0, 1);
            else begin
                s = free_top;
                free_top = slot_next[s];
                b = hash_bucket(key);
                slot_key[s] = key;
                slot_owner[s] = tsk;
                slot_busy[s] = 1'b1;
                slot_next[s] = chain_head[b];
                chain_head[b] = s;
                push_beat(STS_OK, s, 0, 0, 0, 0, 1);
            end
        end else begin
            // Wake: walk the chain newest first, releasing matches up to the limit.
            lim = (lim_in < 0) ? 0 : ((lim_in > 64) ? 64 : int'(lim_in));
            b = hash_bucket(key);
            prev = NONE;
            cur = chain_head[b];
            steps = 0;
            woken = 0;
            while (cur < ENTRIES && woken < lim && steps < ENTRIES) begin
                nxt = slot_next[cur];
                steps++;
                if (slot_busy[cur] && slot_key[cur] == key) begin
                    if (prev == NONE) chain_head[b] = nxt;
                    else slot_next[prev] = nxt;
                    slot_busy[cur] = 1'b0;
                    slot_next[cur] = free_top;
                    free_top = cur;
                    woken++;
                    push_beat(STS_OK, 0, slot_owner[cur], 1, woken, 0, 0);
                end else begin
                    prev = cur;
                end
                cur = nxt;
            end
            if (woken == 0) push_beat(STS_OK, 0, 0, 0, 0, 0, 1);
            else pending_results[$].last = 1'b1;
        end
    endfunction

    // Offers one command beat, waits for it to be taken, then maybe idles.
    task automatic send_cmd(logic [1:0] op, logic [63:0] addr, logic [31:0] expv,
                            logic [31:0] curv, bit fault, logic [7:0] tsk,
                            logic signed [31:0] lim, logic [5:0] sidx);
        int gap;
        cmd            <= op;
        word_address   <= addr;
        expected_value <= expv;
        current_value  <= curv;
        read_fault     <= fault;
        task_id        <= tsk;
        wake_limit     <= lim;
        slot_index     <= sidx;
        cmd_valid      <= 1'b1;
        offering = 1'b1;
        do @(posedge clk); while (cmd_stall);
        predict_futex_cmd(op, addr, expv, curv, fault, tsk, lim, sidx);
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, 6);
            cmd_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic go_quiet();
        if (offering) begin
            cmd_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
    endtask

    task automatic drain();
        go_quiet();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_off_cycles > 0) begin
            res_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            res_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Compare each delivered result beat with the oldest expectation.
    always @(posedge clk) begin
        beat_t got, want;
        if (rst_n && res_valid && !res_stall) begin
            got = {status, slot_taken, woken_task, woken_valid, woken_so_far,
                   slot_freed, last};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    function automatic logic [63:0] good_addr();
        return ({$urandom, $urandom} & 64'h0000_7FFF_FFFF_FFFC) | 64'h4;
    endfunction

    // Mostly pool addresses so waiters collect and wakes find them.
    function automatic logic [63:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (r < 72) return addr_pool[$urandom_range(7)];
        if (r < 84) return {$urandom, $urandom};
        if (r < 88) return 64'd0;
        if (r < 92) return KERNEL_BASE - 64'd4 + 64'(4 * $urandom_range(1));
        return addr_pool[$urandom_range(7)] | 64'($urandom_range(1, 3));
    endfunction

    task automatic test_directed();
        logic [63:0] a;
        a = addr_pool[0];
        send_cmd(CMD_WAIT, a, 32'h0, 32'h0, 0, 8'hFF, 0, 0);
        send_cmd(CMD_WAIT, a, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 8'h00, 0, 6'h3F);
        send_cmd(CMD_WAIT, a, 32'h1234, 32'h1235, 0, 8'h11, 0, 0);
        send_cmd(CMD_WAIT, a, 32'h5, 32'h5, 1, 8'h22, 0, 0);
        send_cmd(CMD_WAIT, 64'd0, 32'h5, 32'h5, 0, 8'h22, 0, 0);
        send_cmd(CMD_WAIT, KERNEL_BASE, 32'h0, 32'h0, 0, 8'h22, 0, 0);
        send_cmd(CMD_WAIT, KERNEL_BASE - 64'd4, 32'h0, 32'h0, 0, 8'h33, 0, 0);
        send_cmd(CMD_WAIT, a | 64'd2, 32'h0, 32'h0, 0, 8'h22, 0, 0);
        send_cmd(CMD_WAKE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 32'sd5, 0);
        send_cmd(CMD_UNSUP, a | 64'd1, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_UNSUP, a, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_WAKE, a, 0, 0, 0, 0, 32'sd0, 0);
        send_cmd(CMD_WAKE, a, 0, 0, 0, 0, 32'h8000_0000, 0);
        send_cmd(CMD_WAKE, addr_pool[1], 0, 0, 0, 0, 32'sd3, 0);
        send_cmd(CMD_CANCEL, 64'd0, 0, 0, 0, 8'h12, 0, 6'd0);
        send_cmd(CMD_CANCEL, 64'd0, 0, 0, 0, 8'h00, 0, 6'd40);
        send_cmd(CMD_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 8'hFF, 0, 6'd0);
        send_cmd(CMD_WAKE, KERNEL_BASE - 64'd4, 0, 0, 0, 0, 32'sd1, 0);
        send_cmd(CMD_WAKE, a, 0, 0, 0, 0, 32'sd1, 0);
        drain();
    endtask

    // Fill every slot on one address, hit the full case, then wake all 64.
    task automatic test_full_table_and_mass_wake();
        logic [63:0] a;
        a = addr_pool[2];
        while (free_top < ENTRIES)
            send_cmd(CMD_WAIT, a, 32'h77, 32'h77, 0, 8'($urandom), 0, 0);
        send_cmd(CMD_WAIT, addr_pool[3], 32'h1, 32'h1, 0, 8'h44, 0, 0);
        send_cmd(CMD_WAKE, a, 0, 0, 0, 0, 32'sh7FFF_FFFF, 0);
        drain();
    endtask

    task automatic random_cmd();
        int r, s, tries;
        logic [31:0] v;
        logic [7:0] tsk;
        logic signed [31:0] lim;
        r = $urandom_range(99);
        v = $urandom;
        if (r < 45) begin
            send_cmd(CMD_WAIT, pick_addr(), v, ($urandom_range(9) == 0) ? $urandom : v,
                     $urandom_range(19) == 0, 8'($urandom), $urandom, 6'($urandom));
        end else if (r < 75) begin
            case ($urandom_range(5))
                0: lim = $urandom;
                1: lim = -$urandom_range(1, 100);
                2: lim = 64 + $urandom_range(100);
                default: lim = $urandom_range(0, 4);
            endcase
            send_cmd(CMD_WAKE, pick_addr(), $urandom, $urandom, 1'($urandom_range(1)),
                     8'($urandom), lim, 6'($urandom));
        end else if (r < 93) begin
            s = $urandom_range(ENTRIES - 1);
            tries = 0;
            while (!slot_busy[s] && tries < 8) begin
                s = $urandom_range(ENTRIES - 1);
                tries++;
            end
            tsk = ($urandom_range(3) != 0) ? slot_owner[s] : 8'($urandom);
            send_cmd(CMD_CANCEL, {$urandom, $urandom}, $urandom, $urandom,
                     1'($urandom_range(1)), tsk, $urandom, 6'(s));
        end else begin
            send_cmd(CMD_UNSUP, pick_addr(), $urandom, $urandom, 1'($urandom_range(1)),
                     8'($urandom), $urandom, 6'($urandom));
        end
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) random_cmd();
        drain();
    endtask

    // Receiver holds off a long while; the engine fills and stalls commands.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 400;
        repeat (6) send_cmd(CMD_WAIT, addr_pool[4], 32'h9, 32'h9, 0, 8'($urandom), 0, 0);
        send_cmd(CMD_WAKE, addr_pool[4], 0, 0, 0, 0, 32'sd10, 0);
        repeat (6) random_cmd();
        drain();
    endtask

    initial begin
        for (int i = 0; i < 8; i++)
            addr_pool[i] = good_addr();
        clear_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table_and_mass_wake();
        test_random_phase(0, 0, 7);
        test_random_phase(49, 0, 7);
        test_random_phase(0, 49, 7);
        test_random_phase(14, 14, 7);
        test_backpressure();

        // Leave room for stray beats before the verdict.
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** futex_wait_table_engine_core: PASSED **");
        else
            $display("** futex_wait_table_engine_core: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
design/fwte_pkg.sv
design/fwte_key_unit.sv
design/fwte_table.sv
design/futex_wait_table_engine_core.sv
tb/testbench.sv
